FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RC4 core. Each macro takes a
// label, clock, active-low reset, antecedent, consequent and message.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: design/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and controller/datapath interface types for the RC4 core.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W      = 8;
    localparam int SBOX_DEPTH  = 256;
    localparam int KEY_MAX_DEF = 256;

    localparam logic [BYTE_W-1:0] SBOX_LAST = BYTE_W'(SBOX_DEPTH - 1);

    // Item command codes
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic init_wr;    // identity sweep write
        logic issue;      // read S[i+1] and key byte, advance i
        logic phase_j;    // capture S[i], update j, read S[j]
        logic phase_sw;   // write S[i] = S[j], read S[t]
        logic fin_wr;     // write S[j] = old S[i]
        logic out_load;   // load result register
        logic data_load;  // capture data byte
        logic key_wr;     // store key byte
        logic ksa;        // key schedule mode: add key byte into j
        logic ksa_start;  // latch key length, preset indices for schedule
        logic ksa_done;   // clear indices, mark keyed
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cnt_last;   // sweep at last entry
        logic i_last;     // schedule index at last entry
        logic out_valid;  // result register holds a result
    } t_dp_sts;

endpackage

FILE: design/rc4_dp.sv
// ----------------------------------------------------------------------------
// rc4_dp
// RC4 datapath: S box memory with one write and one registered read port,
// key store memory, stream indices, key counter and result register.
// ----------------------------------------------------------------------------
module rc4_dp #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rc4_pkg::t_dp_cmd             i_cmd,
    output rc4_pkg::t_dp_sts             o_sts,
    input  logic [rc4_pkg::BYTE_W-1:0]   i_key_byte,
    input  logic [rc4_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [rc4_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                         o_keyed
);

    localparam int BW = rc4_pkg::BYTE_W;
    localparam int CW = $clog2(KEY_MAX + 1);
    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    logic [BW-1:0] r_sbox [rc4_pkg::SBOX_DEPTH];
    logic [BW-1:0] r_kmem [KEY_MAX];

    logic [BW-1:0] r_i;
    logic [BW-1:0] r_j;
    logic [BW-1:0] r_cnt;
    logic [BW-1:0] r_a;
    logic [BW-1:0] r_t;
    logic [BW-1:0] r_sq;
    logic          r_fwd;
    logic [BW-1:0] r_fwd_val;
    logic [BW-1:0] r_key_q;
    logic [BW-1:0] r_data;
    logic [CW-1:0] r_kcnt;
    logic [CW-1:0] r_klen;
    logic [KW-1:0] r_kidx;
    logic          r_keyed;
    logic          r_ov;
    logic [BW-1:0] r_out;
    logic          r_out_keyed;

    logic [BW-1:0] rd;
    logic [BW-1:0] j1;
    logic [BW-1:0] t_sum;
    logic [BW-1:0] ks;
    logic          rd_en;
    logic [BW-1:0] raddr;
    logic          we;
    logic [BW-1:0] waddr;
    logic [BW-1:0] wdata;
    logic          key_room;
    logic [CW-1:0] n_kcnt;
    logic [KW-1:0] n_kidx;

    // Read data, with a same-cycle write to the read address forwarded
    assign rd    = r_fwd ? r_fwd_val : r_sq;
    assign j1    = r_j + rd + (i_cmd.ksa ? r_key_q : '0);
    assign t_sum = r_a + rd;
    // S[t] was read before S[j] got its new value
    assign ks    = (r_t == r_j) ? r_a : rd;

    assign key_room = (r_kcnt < CW'(KEY_MAX));
    assign n_kcnt   = key_room ? (r_kcnt + CW'(1)) : r_kcnt;
    assign n_kidx   = ((CW'(r_kidx) + CW'(1)) == r_klen) ? '0 : (r_kidx + KW'(1));

    always_comb begin
        rd_en = i_cmd.issue | i_cmd.phase_j | i_cmd.phase_sw;
        if (i_cmd.issue) begin
            raddr = r_i + BW'(1);
        end else if (i_cmd.phase_j) begin
            raddr = j1;
        end else begin
            raddr = t_sum;
        end

        we = i_cmd.init_wr | i_cmd.phase_sw | i_cmd.fin_wr;
        if (i_cmd.init_wr) begin
            waddr = r_cnt;
            wdata = r_cnt;
        end else if (i_cmd.phase_sw) begin
            waddr = r_i;
            wdata = rd;
        end else begin
            waddr = r_j;
            wdata = r_a;
        end
    end

    // S box memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_sbox[waddr] <= wdata;
        end
        if (rd_en) begin
            r_sq      <= r_sbox[raddr];
            r_fwd     <= we && (raddr == waddr);
            r_fwd_val <= wdata;
        end
    end

    // Key store memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr && key_room) begin
            r_kmem[r_kcnt[KW-1:0]] <= i_key_byte;
        end
        if (i_cmd.issue) begin
            r_key_q <= r_kmem[r_kidx];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.phase_j) begin
            r_a <= rd;
        end
        if (i_cmd.phase_sw) begin
            r_t <= t_sum;
        end
        if (i_cmd.data_load) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.ksa_start) begin
            r_klen <= n_kcnt;
            r_kidx <= '0;
        end else if (i_cmd.issue && i_cmd.ksa) begin
            r_kidx <= n_kidx;
        end
        if (i_cmd.out_load) begin
            r_out       <= r_data ^ ks;
            r_out_keyed <= r_keyed;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_kcnt  <= '0;
            r_keyed <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.init_wr) begin
                r_cnt <= r_cnt + BW'(1);
            end

            if (i_cmd.ksa_start) begin
                r_i <= rc4_pkg::SBOX_LAST;
            end else if (i_cmd.ksa_done) begin
                r_i <= '0;
            end else if (i_cmd.issue) begin
                r_i <= r_i + BW'(1);
            end

            if (i_cmd.ksa_start || i_cmd.ksa_done) begin
                r_j <= '0;
            end else if (i_cmd.phase_j) begin
                r_j <= j1;
            end

            if (i_cmd.key_wr) begin
                r_kcnt <= i_cmd.ksa_start ? '0 : n_kcnt;
            end

            if (i_cmd.ksa_done) begin
                r_keyed <= 1'b1;
            end

            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.cnt_last  = (r_cnt == rc4_pkg::SBOX_LAST);
    assign o_sts.i_last    = (r_i == rc4_pkg::SBOX_LAST);
    assign o_sts.out_valid = r_ov;

    assign o_valid    = r_ov;
    assign o_out_byte = r_out;
    assign o_keyed    = r_out_keyed;

endmodule

FILE: design/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// RC4 controller: identity sweep, key schedule steps, keystream steps and
// the input/output handshake.
// ----------------------------------------------------------------------------
module rc4_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_command,
    input  logic             i_key_last,
    input  logic             i_out_stall,
    input  rc4_pkg::t_dp_sts i_sts,
    output rc4_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_KSA_RD = 3'd2;
    localparam logic [2:0] ST_J      = 3'd3;
    localparam logic [2:0] ST_SW     = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_ksa;
    logic       n_ksa;
    logic       r_to_ksa;
    logic       n_to_ksa;
    logic       accept_ok;
    logic       out_free;

    assign out_free = !i_sts.out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_ksa     = r_ksa;
        n_to_ksa  = r_to_ksa;
        o_cmd     = '0;
        accept_ok = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state  = r_to_ksa ? ST_KSA_RD : ST_IDLE;
                    n_to_ksa = 1'b0;
                end
            end
            ST_IDLE: begin
                accept_ok = 1'b1;
            end
            ST_KSA_RD: begin
                o_cmd.issue = 1'b1;
                o_cmd.ksa   = 1'b1;
                n_state     = ST_J;
            end
            ST_J: begin
                o_cmd.phase_j = 1'b1;
                o_cmd.ksa     = r_ksa;
                n_state       = ST_SW;
            end
            ST_SW: begin
                o_cmd.phase_sw = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.fin_wr = 1'b1;
                if (r_ksa) begin
                    o_cmd.ksa = 1'b1;
                    if (i_sts.i_last) begin
                        o_cmd.ksa_done = 1'b1;
                        n_ksa          = 1'b0;
                        n_state        = ST_IDLE;
                    end else begin
                        o_cmd.issue = 1'b1;
                        n_state     = ST_J;
                    end
                end else if (out_free) begin
                    // hold in this state until the result register frees up
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                    accept_ok      = 1'b1;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase

        if (accept_ok && i_valid) begin
            if (i_command == rc4_pkg::CMD_DATA) begin
                o_cmd.issue     = 1'b1;
                o_cmd.data_load = 1'b1;
                n_ksa           = 1'b0;
                n_state         = ST_J;
            end else begin
                o_cmd.key_wr = 1'b1;
                if (i_key_last) begin
                    o_cmd.ksa_start = 1'b1;
                    n_ksa           = 1'b1;
                    n_to_ksa        = 1'b1;
                    n_state         = ST_INIT;
                end
            end
        end
    end

    assign o_stall = !accept_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_ksa    <= 1'b0;
            r_to_ksa <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ksa    <= n_ksa;
            r_to_ksa <= n_to_ksa;
        end
    end

endmodule

FILE: design/rc4_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// Data item: the transfer reads S[i+1]; states J, SW and FIN run the S box
// read/swap/read sequence, the result is registered in FIN and the next item
// is taken on that same edge; FIN holds while the result waits on a stall.
// Key byte: stored. Last key byte: identity sweep, setup state, 256 swap steps
// (J, SW, FIN), no input taken. Reset: synchronous, identity sweep first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_stream_cipher_core #(
    parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_command,
    input  logic [rc4_pkg::BYTE_W-1:0] i_key_byte,
    input  logic                       i_key_last,
    input  logic [rc4_pkg::BYTE_W-1:0] i_data_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [rc4_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_keyed
);

    rc4_pkg::t_dp_cmd cmd;
    rc4_pkg::t_dp_sts sts;

    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_key_last  (i_key_last),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rc4_dp #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_key_byte  (i_key_byte),
        .i_data_byte (i_data_byte),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_keyed     (o_keyed)
    );

    // Result register is never overwritten while it still waits
    `ASSERT_IMPL(a_out_no_overwrite, i_clk, i_rst_n, cmd.out_load, !o_valid || !i_stall, "result overwritten while stalled")

    // A data transfer starts the keystream step on the next cycle
    `ASSERT_NEXT(a_data_step, i_clk, i_rst_n, i_valid && !o_stall && (i_command == rc4_pkg::CMD_DATA), cmd.phase_j, "data transfer did not start a step")

    // S box phases never overlap
    `ASSERT_IMPL(a_phase_excl, i_clk, i_rst_n, 1'b1, $onehot0({cmd.init_wr, cmd.issue, cmd.phase_j, cmd.phase_sw}), "overlapping S box phases")

    // No transfer during the identity sweep
    `ASSERT_IMPL(a_sweep_stall, i_clk, i_rst_n, cmd.init_wr, o_stall, "input taken during S box sweep")

endmodule

FILE: test/rc4_stream_cipher_core_test.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core_test
// Self-checking bench for the RC4 core. A directed table covers the reset
// S box, short and overlong keys, partial keys and ignored fields. Random
// key/data sequences follow. Data transfers are checked against a local
// keystream predictor or typed row results, with random input and output gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rc4_stream_cipher_core_test;

    localparam int TOTAL_ITEMS  = 850;
    localparam int DRAIN_CYCLES = 1100;  // covers a full key schedule

    typedef struct packed {
        logic [7:0] out_byte;
        logic       keyed;
    } t_cipher_res;

    typedef struct packed {
        logic       cmd;
        logic [7:0] key_byte;
        logic       key_last;
        logic [7:0] data_byte;
        logic [9:0] reps;
        logic       typed;
        logic [7:0] exp_byte;
        logic       exp_keyed;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_command;
    logic [7:0] i_key_byte;
    logic       i_key_last;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_keyed;

    // Predictor state
    logic [7:0] sbox_m [256];
    logic [7:0] key_mem [256];
    int         key_len;
    logic [7:0] ks_i;
    logic [7:0] ks_j;
    logic       have_key;

    t_cipher_res expected_q [$];
    t_stim_row   dir_rows [$];
    t_cipher_res want_res;
    int          err_count = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          send_quiet = 0;
    int          stall_quiet = 0;

    rc4_stream_cipher_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_key_byte  (i_key_byte),
        .i_key_last  (i_key_last),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_keyed     (o_keyed)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_idle(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet = $urandom_range(20, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the keystream predictor by one item; returns 1 when it yields a result.
    function automatic bit rc4_model_step(input logic cmd, input logic [7:0] kb,
                                          input logic kl, input logic [7:0] db,
                                          output t_cipher_res res);
        int         k;
        logic [7:0] acc;
        logic [7:0] tmp;
        logic [7:0] t;
        res = '0;
        if (cmd == rc4_pkg::CMD_KEY) begin
            // drop key bytes once the store is full
            if (key_len < rc4_pkg::KEY_MAX_DEF) begin
                key_mem[key_len] = kb;
                key_len++;
            end
            if (kl) begin
                for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++) sbox_m[k] = k[7:0];
                acc = 8'd0;
                for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++) begin
                    acc = acc + sbox_m[k] + key_mem[k % key_len];
                    tmp = sbox_m[k];
                    sbox_m[k] = sbox_m[acc];
                    sbox_m[acc] = tmp;
                end
                ks_i = 8'd0;
                ks_j = 8'd0;
                key_len = 0;
                have_key = 1'b1;
            end
            return 1'b0;
        end
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + sbox_m[ks_i];
        tmp = sbox_m[ks_i];
        sbox_m[ks_i] = sbox_m[ks_j];
        sbox_m[ks_j] = tmp;
        t = sbox_m[ks_i] + sbox_m[ks_j];
        res.out_byte = db ^ sbox_m[t];
        res.keyed = have_key;
        return 1'b1;
    endfunction

    function automatic void add_row(input logic cmd, input logic [7:0] kb,
                                    input logic kl, input logic [7:0] db,
                                    input int reps, input logic typed,
                                    input logic [7:0] eb, input logic ek);
        t_stim_row row;
        row.cmd = cmd;
        row.key_byte = kb;
        row.key_last = kl;
        row.data_byte = db;
        row.reps = reps[9:0];
        row.typed = typed;
        row.exp_byte = eb;
        row.exp_keyed = ek;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Present one item after a random gap, hold it until the transfer, then predict.
    task automatic send_item(input logic cmd, input logic [7:0] kb, input logic kl,
                             input logic [7:0] db, input logic typed,
                             input t_cipher_res typed_res);
        int          gap;
        t_cipher_res res;
        gap = pick_idle(send_quiet);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_data_byte <= 8'($urandom_range(0, 255));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_command <= cmd;
        i_key_byte <= kb;
        i_key_last <= kl;
        i_data_byte <= db;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        items_sent++;
        if (rc4_model_step(cmd, kb, kl, db, res))
            expected_q.insert(expected_q.size(), typed ? typed_res : res);
    endtask

    task automatic send_key(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_item(rc4_pkg::CMD_KEY, 8'($urandom_range(0, 255)), k == len - 1,
                      8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic send_data(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_item(rc4_pkg::CMD_DATA, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Output side stall
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = pick_idle(stall_quiet);
            if (n > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("result %0d: none expected, got out_byte=%02h keyed=%0d",
                             results_seen, o_out_byte, o_keyed);
            end else begin
                want_res = expected_q.pop_front();
                if (o_out_byte !== want_res.out_byte || o_keyed !== want_res.keyed) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result %0d: expected %02h/%0d, got %02h/%0d",
                                 results_seen, want_res.out_byte, want_res.keyed,
                                 o_out_byte, o_keyed);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_stim_row   row;
        t_cipher_res typed_res;
        int          rep;
        int          k;
        int          r;
        int          len;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = rc4_pkg::CMD_KEY;
        i_key_byte = 8'd0;
        i_key_last = 1'b0;
        i_data_byte = 8'd0;
        for (k = 0; k < rc4_pkg::SBOX_DEPTH; k++) begin
            sbox_m[k] = k[7:0];
            key_mem[k] = 8'd0;
        end
        key_len = 0;
        ks_i = 8'd0;
        ks_j = 8'd0;
        have_key = 1'b0;

        // Data before any key runs on the identity S box
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00, 1, 1'b1, 8'h02, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'hFF, 1'b0, 8'hFF, 1, 1'b1, 8'hFA, 1'b0);
        // Three-byte ASCII key, then plaintext
        add_row(rc4_pkg::CMD_KEY,  8'h4B, 1'b0, 8'hFF, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_KEY,  8'h65, 1'b0, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_KEY,  8'h79, 1'b1, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h50, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h6C, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h61, 1, 1'b0, 8'h00, 1'b0);
        // Shortest keys at both byte extremes
        add_row(rc4_pkg::CMD_KEY,  8'h00, 1'b1, 8'hFF, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'hFF, 1'b0, 8'hFF, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_KEY,  8'hFF, 1'b1, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'hA5, 1, 1'b0, 8'h00, 1'b0);
        // Key flags on a data item are ignored
        add_row(rc4_pkg::CMD_DATA, 8'hFF, 1'b1, 8'h3C, 1, 1'b0, 8'h00, 1'b0);
        // Overlong key: store fills, the last byte still starts the schedule
        add_row(rc4_pkg::CMD_KEY,  8'h80, 1'b1, 8'h00, 300, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h5A, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        // Partial key, data in between keeps the old S box
        add_row(rc4_pkg::CMD_KEY,  8'h12, 1'b0, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_KEY,  8'h34, 1'b0, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'h77, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_KEY,  8'h56, 1'b1, 8'h00, 1, 1'b0, 8'h00, 1'b0);
        add_row(rc4_pkg::CMD_DATA, 8'h00, 1'b0, 8'hFF, 1, 1'b0, 8'h00, 1'b0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            row = dir_rows[n];
            typed_res = '0;
            typed_res.out_byte = row.exp_byte;
            typed_res.keyed = row.exp_keyed;
            for (rep = 0; rep < row.reps; rep++)
                send_item(row.cmd, row.key_byte + rep[7:0],
                          row.key_last && (rep == row.reps - 1),
                          row.data_byte, row.typed, typed_res);
        end

        while (items_sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                k = $urandom_range(0, 99);
                if (k < 2)       len = $urandom_range(250, 270);
                else if (k < 20) len = $urandom_range(17, 64);
                else             len = $urandom_range(1, 16);
                send_key(len);
                send_data($urandom_range(1, 40));
            end else if (r < 85) begin
                send_data($urandom_range(1, 20));
            end else if (r < 95) begin
                // broken key load: no last flag before data arrives
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                    send_item(rc4_pkg::CMD_KEY, 8'($urandom_range(0, 255)), 1'b0,
                              8'($urandom_range(0, 255)), 1'b0, '0);
                send_data($urandom_range(1, 10));
            end else begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'b0, '0);
            end
        end
        // finish on data so the last schedule is flushed out by results
        send_data(4);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/rc4_pkg.sv
design/rc4_dp.sv
design/rc4_ctrl.sv
design/rc4_stream_cipher_core.sv
test/rc4_stream_cipher_core_test.sv
